// File: rtl/bpfa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpfa_pkg
// Shared types and constants of the bitmap page frame allocator.
// ----------------------------------------------------------------------------
package bpfa_pkg;

    localparam int WORD_W     = 32;   // map bits held in one memory word
    localparam int BIT_W      = 5;    // log2(WORD_W)
    localparam int CNT_W      = 11;   // num_pages / usable_pages width
    localparam int ADDR_W     = 32;
    localparam int SHIFT_W    = 5;
    localparam int REGIDX_W   = 2;
    localparam int IN_TDATA_W = 48;   // num_pages + addr, padded to bytes
    localparam int OUT_TDATA_W = 32;

    localparam logic [REGIDX_W-1:0] CFG_BASE_ADDR    = 2'd0;
    localparam logic [REGIDX_W-1:0] CFG_PAGE_SHIFT   = 2'd1;
    localparam logic [REGIDX_W-1:0] CFG_USABLE_PAGES = 2'd2;

    localparam logic [ADDR_W-1:0]  RST_BASE_ADDR    = 32'h0010_0000;
    localparam logic [SHIFT_W-1:0] RST_PAGE_SHIFT   = 5'd12;
    localparam logic [CNT_W-1:0]   RST_USABLE_PAGES = 11'd1024;

    localparam logic MODE_FREE = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PREP,
        ST_CHECK,
        ST_SCAN,
        ST_MARK_INIT,
        ST_MARK,
        ST_FINISH
    } bpfa_state_t;

    typedef struct packed {
        logic load;
        logic calc_idx;
        logic check;
        logic scan_init;
        logic scan_run;
        logic mark_init;
        logic mark_run;
        logic clr_run;
        logic finish;
    } bpfa_cmd_t;

    typedef struct packed {
        logic clr_done;
        logic mode;
        logic pre_ok;
        logic scan_hit;
        logic scan_miss;
        logic mark_done;
    } bpfa_stat_t;

endpackage
`default_nettype wire

// File: rtl/bpfa_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpfa_ctrl
// Sequencer: clear pass, request decode, scan, mark and result hand-off.
// ----------------------------------------------------------------------------
module bpfa_ctrl
    import bpfa_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output bpfa_cmd_t       cmd,
    input  wire bpfa_stat_t stat
);

    bpfa_state_t state_reg, state_next;
    logic        out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        s_tready       = 1'b0;
        out_valid_next = out_valid_reg && !m_tready;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_run = 1'b1;
                if (stat.clr_done)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                cmd.calc_idx = 1'b1;
                state_next   = ST_CHECK;
            end
            ST_CHECK:
            begin
                cmd.check = 1'b1;
                if (!stat.pre_ok)
                    state_next = ST_FINISH;
                else if (stat.mode == MODE_FREE)
                    state_next = ST_MARK_INIT;
                else
                begin
                    cmd.scan_init = 1'b1;
                    state_next    = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan_run = 1'b1;
                if (stat.scan_hit)
                    state_next = ST_MARK_INIT;
                else if (stat.scan_miss)
                    state_next = ST_FINISH;
            end
            ST_MARK_INIT:
            begin
                cmd.mark_init = 1'b1;
                state_next    = ST_MARK;
            end
            ST_MARK:
            begin
                cmd.mark_run = 1'b1;
                if (stat.mark_done)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                // hold until the output register is free or being drained
                if (!out_valid_reg || m_tready)
                begin
                    cmd.finish     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;

    a_valid_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_FINISH))
        else $error("result valid raised outside finish");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> (!out_valid_reg || m_tready))
        else $error("pending result overwritten");

    a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CLEAR |-> !out_valid_reg)
        else $error("result pending during clear pass");

endmodule
`default_nettype wire

// File: rtl/bpfa_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpfa_datapath
// Config registers, used-map memory, word-wide first-fit scan and run marking.
// ----------------------------------------------------------------------------
module bpfa_datapath
    import bpfa_pkg::*;
#(
    parameter int PAGES = 1024
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_valid,
    input  wire logic [REGIDX_W-1:0] cfg_index,
    input  wire logic [ADDR_W-1:0]   cfg_data,
    input  wire logic                in_mode,
    input  wire logic [CNT_W-1:0]    in_count,
    input  wire logic [ADDR_W-1:0]   in_addr,
    input  wire bpfa_cmd_t           cmd,
    output bpfa_stat_t               stat,
    output logic [ADDR_W-1:0]        result_addr,
    output logic                     result_ok
);

    localparam int WORDS = (PAGES + WORD_W - 1) / WORD_W;
    localparam int WAW   = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int PPW   = WAW + BIT_W;
    localparam int PIW   = $clog2(PAGES + 1);
    localparam int XW    = ((PPW > CNT_W) ? PPW : CNT_W) + 1;
    localparam logic [XW-1:0] PAGES_X = XW'(PAGES);

    // configuration
    logic [ADDR_W-1:0]  base_reg;
    logic [SHIFT_W-1:0] shift_reg;
    logic [CNT_W-1:0]   usable_reg;

    // request
    logic              mode_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [PIW-1:0]    limit_reg;
    logic [ADDR_W-1:0] idx_reg;
    logic [PPW-1:0]    lo_reg, hi_reg;
    logic              succ_reg;

    // map access sequencing
    logic [WAW-1:0] rd_word_reg, end_word_reg, eval_word_reg, clr_word_reg;
    logic           rd_done_reg, pend_reg;
    logic [XW-1:0]  carry_reg, carry_next;
    logic [WORD_W-1:0] rd_data_reg;
    logic [WORD_W-1:0] map_mem [WORDS];

    logic [ADDR_W-1:0] res_addr_reg;
    logic              res_ok_reg;

    logic [XW-1:0]  count_x, limit_x, usable_x;
    logic [WAW-1:0] last_word;
    logic           pre_ok;

    logic [WORD_W-1:0] eff, hit, mask, mark_word;
    logic              hit_any, any_used;
    logic [BIT_W-1:0]  hit_pos, top_used;
    logic [PPW-1:0]    hit_hi, hit_lo;
    logic              rd_en, wr_en;
    logic [WAW-1:0]    wr_addr;
    logic [WORD_W-1:0] wr_data;
    logic              scan_hit, scan_miss, mark_done, clr_done;

    assign count_x  = XW'(count_reg);
    assign limit_x  = XW'(limit_reg);
    assign usable_x = XW'(usable_reg);
    assign last_word = WAW'((limit_x - XW'(1)) >> BIT_W);

    always_comb
    begin
        if (mode_reg == MODE_FREE)
            pre_ok = (count_reg != '0) &&
                     ({1'b0, idx_reg} + (ADDR_W + 1)'(count_reg) <= (ADDR_W + 1)'(limit_reg));
        else
            pre_ok = (count_reg != '0) && (count_x <= limit_x);
    end

    // per-bit view of the word under evaluation; pages past the limit count as used
    always_comb
    begin
        logic [WORD_W-1:0] win;
        logic [XW-1:0]     pos;
        for (int j = 0; j < WORD_W; j++)
        begin
            pos    = XW'({eval_word_reg, BIT_W'(j)});
            eff[j] = rd_data_reg[j] | (pos >= limit_x);
        end
        for (int j = 0; j < WORD_W; j++)
        begin
            // window of count pages ending at bit j, clipped to this word
            for (int k = 0; k < WORD_W; k++)
                win[k] = (k <= j) && (XW'(k) + count_x > XW'(j));
            hit[j] = !(|(eff & win)) && (carry_reg + XW'(j) + XW'(1) >= count_x);
        end
    end

    always_comb
    begin
        hit_any  = |hit;
        hit_pos  = '0;
        for (int j = WORD_W - 1; j >= 0; j--)
            if (hit[j])
                hit_pos = BIT_W'(j);
        any_used = |eff;
        top_used = '0;
        for (int j = 0; j < WORD_W; j++)
            if (eff[j])
                top_used = BIT_W'(j);
        if (any_used)
            carry_next = XW'(WORD_W - 1) - XW'(top_used);
        else
            carry_next = carry_reg + XW'(WORD_W);
    end

    assign hit_hi = {eval_word_reg, hit_pos};
    assign hit_lo = hit_hi - PPW'(count_reg) + PPW'(1);

    always_comb
    begin
        logic [PPW-1:0] p;
        for (int j = 0; j < WORD_W; j++)
        begin
            p       = {eval_word_reg, BIT_W'(j)};
            mask[j] = (p >= lo_reg) && (p <= hi_reg);
        end
        if (mode_reg == MODE_FREE)
            mark_word = rd_data_reg & ~mask;
        else
            mark_word = rd_data_reg | mask;
    end

    assign scan_hit  = cmd.scan_run && pend_reg && hit_any;
    assign scan_miss = cmd.scan_run && pend_reg && !hit_any && (eval_word_reg == end_word_reg);
    assign mark_done = cmd.mark_run && pend_reg && (eval_word_reg == end_word_reg);
    assign clr_done  = cmd.clr_run && (clr_word_reg == WAW'(WORDS - 1));

    assign rd_en   = (cmd.scan_run || cmd.mark_run) && !rd_done_reg;
    assign wr_en   = cmd.clr_run || (cmd.mark_run && pend_reg);
    assign wr_addr = cmd.clr_run ? clr_word_reg : eval_word_reg;
    assign wr_data = cmd.clr_run ? '0 : mark_word;

    // used map
    always_ff @(posedge clk)
    begin
        if (wr_en)
            map_mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= map_mem[rd_word_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg   <= RST_BASE_ADDR;
            shift_reg  <= RST_PAGE_SHIFT;
            usable_reg <= RST_USABLE_PAGES;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_BASE_ADDR:    base_reg   <= cfg_data;
                CFG_PAGE_SHIFT:   shift_reg  <= cfg_data[SHIFT_W-1:0];
                CFG_USABLE_PAGES: usable_reg <= cfg_data[CNT_W-1:0];
                default:          ;
            endcase
        end
    end

    // control-side registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_word_reg <= '0;
            rd_done_reg  <= 1'b1;
            pend_reg     <= 1'b0;
            succ_reg     <= 1'b0;
        end
        else
        begin
            if (cmd.clr_run)
                clr_word_reg <= clr_word_reg + WAW'(1);
            if (cmd.load)
                succ_reg <= 1'b0;
            else if (mark_done)
                succ_reg <= 1'b1;
            if (cmd.scan_init || cmd.mark_init)
            begin
                rd_done_reg <= 1'b0;
                pend_reg    <= 1'b0;
            end
            else if (cmd.scan_run || cmd.mark_run)
            begin
                pend_reg <= rd_en;
                if (rd_en && (rd_word_reg == end_word_reg))
                    rd_done_reg <= 1'b1;
            end
            else
                pend_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg  <= in_mode;
            count_reg <= in_count;
            addr_reg  <= in_addr;
            limit_reg <= PIW'((usable_x > PAGES_X) ? PAGES_X : usable_x);
        end
        if (cmd.calc_idx)
            idx_reg <= (addr_reg - base_reg) >> shift_reg;
        if (cmd.check && (mode_reg == MODE_FREE))
        begin
            lo_reg <= idx_reg[PPW-1:0];
            hi_reg <= idx_reg[PPW-1:0] + PPW'(count_reg) - PPW'(1);
        end
        if (scan_hit)
        begin
            lo_reg <= hit_lo;
            hi_reg <= hit_hi;
        end
        if (cmd.scan_init)
        begin
            rd_word_reg  <= '0;
            end_word_reg <= last_word;
            carry_reg    <= '0;
        end
        else if (cmd.mark_init)
        begin
            rd_word_reg  <= lo_reg[PPW-1:BIT_W];
            end_word_reg <= hi_reg[PPW-1:BIT_W];
        end
        else if (rd_en)
        begin
            eval_word_reg <= rd_word_reg;
            if (rd_word_reg != end_word_reg)
                rd_word_reg <= rd_word_reg + WAW'(1);
        end
        if (cmd.scan_run && pend_reg)
            carry_reg <= carry_next;
        if (cmd.finish)
        begin
            res_ok_reg <= succ_reg;
            if (mode_reg == MODE_FREE)
                res_addr_reg <= addr_reg;
            else if (succ_reg)
                res_addr_reg <= base_reg + (ADDR_W'(lo_reg) << shift_reg);
            else
                res_addr_reg <= '0;
        end
    end

    always_comb
    begin
        stat.clr_done  = clr_done;
        stat.mode      = mode_reg;
        stat.pre_ok    = pre_ok;
        stat.scan_hit  = scan_hit;
        stat.scan_miss = scan_miss;
        stat.mark_done = mark_done;
    end

    assign result_addr = res_addr_reg;
    assign result_ok   = res_ok_reg;

    a_hit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        scan_hit |-> (XW'(hit_hi) < limit_x))
        else $error("allocated run extends past managed pages");

    a_mark_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && !cmd.clr_run) |-> (eval_word_reg <= end_word_reg))
        else $error("map write past end of run");

    a_clear_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clr_run |-> (!cmd.scan_run && !cmd.mark_run && !cmd.load))
        else $error("map access during clear pass");

endmodule
`default_nettype wire

// File: rtl/bitmap_page_frame_allocator_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bitmap_page_frame_allocator_unit
// First-fit page frame allocator over a one-bit-per-page used map.
// ----------------------------------------------------------------------------
// Usage:
//  - Request stream (s_*): tuser = mode (0 allocate, 1 free), tdata carries
//    num_pages and addr. One request is worked at a time; s_tready is high
//    only while the unit is idle.
//  - Result stream (m_*): tdata = result_addr, tuser = ok. Exactly one result
//    per request. Result sits in an output register; the unit returns to idle
//    and takes the next request while that result waits for m_tready. A stall
//    only holds the unit once the next result is ready to be written.
//  - Config channel (cfg_*): always ready; index 0 base_addr, 1 page_shift,
//    2 usable_pages, other indexes ignored. Write only while idle.
// Flow (W = 32 map bits per memory word), each after accept, index and check:
//  - Rejected request: goes straight to the result.
//  - Free: marks the words touched by the run, then gives the result.
//  - Allocate: scans the words up to the hit, then marks the words in the run;
//    with no fitting run, the scan runs to the last managed page's word.
//    The scan covers one memory word per cycle, marking does one
//    read-modify-write per cycle, both through the single map memory.
// Reset: the map memory is cleared by a sweep over all ceil(PAGES/32) words
//  (32 at PAGES = 1024) before the first request is taken.
// ----------------------------------------------------------------------------
module bitmap_page_frame_allocator_unit
    import bpfa_pkg::*;
#(
    parameter int PAGES = 1024
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // request stream
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,   // [10:0] num_pages, [42:11] addr
    input  wire logic                   s_tuser,   // [0] mode
    // result stream
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [OUT_TDATA_W-1:0]      m_tdata,   // [31:0] result_addr
    output logic                        m_tuser,   // [0] ok
    // configuration writes
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [REGIDX_W-1:0]    cfg_index,
    input  wire logic [ADDR_W-1:0]      cfg_data
);

    bpfa_cmd_t  cmd;
    bpfa_stat_t stat;

    // registers are plain flops, a write always completes in one transfer
    assign cfg_ready = 1'b1;

    bpfa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    bpfa_datapath #(
        .PAGES (PAGES)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_mode     (s_tuser),
        .in_count    (s_tdata[CNT_W-1:0]),
        .in_addr     (s_tdata[CNT_W+ADDR_W-1:CNT_W]),
        .cmd         (cmd),
        .stat        (stat),
        .result_addr (m_tdata),
        .result_ok   (m_tuser)
    );

endmodule
`default_nettype wire

// File: dv/tb_bitmap_page_frame_allocator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bitmap_page_frame_allocator_unit
// Self-checking bench for the first-fit page frame allocator. A directed
// table hits the corner cases at reset settings, then random allocate/free
// traffic runs under several register settings. Each result is checked either
// against its table row or against a bench-side copy of the used map and registers.
// ----------------------------------------------------------------------------
module tb_bitmap_page_frame_allocator_unit;
    import bpfa_pkg::*;

    localparam int  PAGES       = 1024;
    localparam int  QUIET_LIMIT = 4000;  // cycles with no transfer before giving up
    localparam int  HOLD_CYCLES = 400;   // long sink hold-off
    localparam int  TAIL_CYCLES = 100;   // settle time after the last result

    localparam logic MODE_ALLOC = ~MODE_FREE;
    localparam logic REQ_OK     = 1'b1;
    localparam logic REQ_FAIL   = 1'b0;
    localparam logic TYPED      = 1'b1;  // row carries its own expected result
    localparam logic PREDICTED  = 1'b0;  // row is checked against the predictor

    // index 3 decodes to nothing; written once to make sure it stays harmless
    localparam logic [REGIDX_W-1:0] CFG_UNMAPPED = 2'd3;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic              ok;
    } frame_result_t;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [CNT_W-1:0]  cnt;
    } page_run_t;

    typedef struct packed {
        logic              mode;
        logic [CNT_W-1:0]  cnt;
        logic [ADDR_W-1:0] addr;
        logic              typed;
        logic [ADDR_W-1:0] exp_addr;
        logic              exp_ok;
    } dir_row_t;

    // Directed table, reset settings: base 0x0010_0000, 4 KiB pages, 1024 pages.
    localparam int DIR_N = 24;
    localparam dir_row_t DIR_ROWS [DIR_N] = '{
        // first allocate after reset lands on page 0
        '{MODE_ALLOC, 11'd1,    32'h0000_0000, TYPED, 32'h0010_0000, REQ_OK},
        // zero count, both operations
        '{MODE_ALLOC, 11'd0,    32'h0000_0000, TYPED, 32'h0000_0000, REQ_FAIL},
        '{MODE_FREE,  11'd0,    32'h0010_0000, TYPED, 32'h0010_0000, REQ_FAIL},
        // no run: whole map wanted while page 0 is taken, then count above usable
        '{MODE_ALLOC, 11'd1024, 32'h0000_0000, TYPED, 32'h0000_0000, REQ_FAIL},
        '{MODE_ALLOC, 11'h7FF,  32'hFFFF_FFFF, TYPED, 32'h0000_0000, REQ_FAIL},
        '{MODE_ALLOC, 11'd3,    32'h0000_0000, TYPED, 32'h0010_1000, REQ_OK},
        // free below base wraps to a huge index; top address likewise
        '{MODE_FREE,  11'd1,    32'h000F_FFFF, TYPED, 32'h000F_FFFF, REQ_FAIL},
        '{MODE_FREE,  11'h7FF,  32'hFFFF_FFFF, TYPED, 32'hFFFF_FFFF, REQ_FAIL},
        // unaligned free rounds down to page 1, which the next allocate reuses
        '{MODE_FREE,  11'd1,    32'h0010_1FFF, TYPED, 32'h0010_1FFF, REQ_OK},
        '{MODE_ALLOC, 11'd1,    32'h0000_0000, TYPED, 32'h0010_1000, REQ_OK},
        // freeing an already free page is fine
        '{MODE_FREE,  11'd1,    32'h0010_5000, TYPED, 32'h0010_5000, REQ_OK},
        // last page: one past the end fails, exactly the end passes
        '{MODE_FREE,  11'd2,    32'h004F_F000, TYPED, 32'h004F_F000, REQ_FAIL},
        '{MODE_FREE,  11'd1,    32'h004F_F000, TYPED, 32'h004F_F000, REQ_OK},
        // addr is ignored on allocate
        '{MODE_ALLOC, 11'd1,    32'hFFFF_FFFF, TYPED, 32'h0010_4000, REQ_OK},
        '{MODE_FREE,  11'd1024, 32'h0010_0000, TYPED, 32'h0010_0000, REQ_OK},
        // full map in one run, then nothing left
        '{MODE_ALLOC, 11'd1024, 32'h0000_0000, TYPED, 32'h0010_0000, REQ_OK},
        '{MODE_ALLOC, 11'd1,    32'h0000_0000, TYPED, 32'h0000_0000, REQ_FAIL},
        '{MODE_FREE,  11'd1024, 32'h0010_0000, TYPED, 32'h0010_0000, REQ_OK},
        '{MODE_ALLOC, 11'd512,  32'hAAAA_AAAA, TYPED, 32'h0010_0000, REQ_OK},
        '{MODE_ALLOC, 11'd512,  32'h5555_5555, TYPED, 32'h0030_0000, REQ_OK},
        '{MODE_FREE,  11'd512,  32'h0030_0000, TYPED, 32'h0030_0000, REQ_OK},
        // run crossing a map word, then one that just misses the end
        '{MODE_ALLOC, 11'd33,   32'h0000_0000, PREDICTED, 32'h0, REQ_FAIL},
        '{MODE_ALLOC, 11'd480,  32'h0000_0000, PREDICTED, 32'h0, REQ_FAIL},
        '{MODE_FREE,  11'd1024, 32'h0010_0000, TYPED, 32'h0010_0000, REQ_OK}
    };

    // ------------------------------------------------------------------
    // DUT hookup; every driven input starts at a known value
    // ------------------------------------------------------------------
    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;   // [10:0] num_pages, [42:11] addr
    logic                   s_tuser   = 1'b0; // [0] mode
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;          // [31:0] result_addr
    logic                   m_tuser;          // [0] ok
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [REGIDX_W-1:0]    cfg_index = '0;
    logic [ADDR_W-1:0]      cfg_data  = '0;

    bitmap_page_frame_allocator_unit #(.PAGES(PAGES)) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Bench copy of the allocator: registers and used map
    // ------------------------------------------------------------------
    logic [ADDR_W-1:0]  cfg_base  = RST_BASE_ADDR;
    logic [SHIFT_W-1:0] cfg_shift = RST_PAGE_SHIFT;
    logic [CNT_W-1:0]   cfg_pages = RST_USABLE_PAGES;
    bit                 used_map [PAGES];

    frame_result_t pending_results [$];   // expected results, oldest first
    page_run_t     held_runs [$];         // runs currently allocated, for clean frees
    int unsigned   mismatch_cnt = 0;
    int unsigned   burst_left   = 0;

    // usable_pages above the map depth is clamped to the depth
    function automatic int managed_pages();
        return (int'(cfg_pages) > PAGES) ? PAGES : int'(cfg_pages);
    endfunction

    // Applies one request to the bench map and returns the result it must give.
    function automatic frame_result_t predict_frame_result(input logic mode,
                                                           input logic [CNT_W-1:0] cnt,
                                                           input logic [ADDR_W-1:0] addr);
        frame_result_t     res;
        int                lim;
        int                run;
        int                p;
        bit                found;
        logic [ADDR_W-1:0] first_page;
        logic [ADDR_W-1:0] idx;
        logic [63:0]       span;
        lim   = managed_pages();
        res   = '{addr: '0, ok: REQ_FAIL};
        found = 1'b0;
        if (mode == MODE_ALLOC)
        begin
            // first fit from page 0; a failed search leaves addr at zero
            if (cnt != 0 && int'(cnt) <= lim)
            begin
                run = 0;
                for (p = 0; p < lim && !found; p++)
                begin
                    run = used_map[p] ? 0 : run + 1;
                    if (run == int'(cnt))
                    begin
                        found      = 1'b1;
                        first_page = ADDR_W'(p + 1 - run);
                        for (int i = 0; i < run; i++)
                            used_map[int'(first_page) + i] = 1'b1;
                        res.addr = cfg_base + (first_page << cfg_shift);
                        res.ok   = REQ_OK;
                    end
                end
            end
        end
        else
        begin
            // page index wraps modulo 2^32; the address is echoed either way
            idx      = (addr - cfg_base) >> cfg_shift;
            span     = {32'd0, idx} + {53'd0, cnt};
            res.addr = addr;
            if (cnt != 0 && span <= 64'(lim))
            begin
                for (int i = 0; i < int'(cnt); i++)
                    used_map[int'(idx) + i] = 1'b0;
                res.ok = REQ_OK;
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what);
        $display("%0t ns: mismatch: %s", $time, what);
        mismatch_cnt++;
    endtask

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------
    // Bursts of back-to-back requests separated by random gaps; about a
    // quarter of the bursts run straight into the next one.
    task automatic pace_requests();
        int unsigned gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
    endtask

    // Offers one request, waits for its transfer and queues what it must return.
    // valid is left high so a following request is offered straight away.
    task automatic issue_request(input logic mode, input logic [CNT_W-1:0] cnt,
                                 input logic [ADDR_W-1:0] addr, input logic typed,
                                 input frame_result_t typed_res);
        frame_result_t res;
        pace_requests();
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {{(IN_TDATA_W - ADDR_W - CNT_W){1'b0}}, addr, cnt};
        do @(posedge clk); while (!s_tready);
        res = predict_frame_result(mode, cnt, addr);
        pending_results.push_back(typed ? typed_res : res);
        if (mode == MODE_ALLOC && res.ok == REQ_OK)
            held_runs.push_back('{addr: res.addr, cnt: cnt});
    endtask

    // Mostly clean alloc/free pairs on runs that are actually held; the rest
    // is zero counts, stray addresses, partial and oversize frees.
    task automatic random_request();
        logic [CNT_W-1:0]  cnt;
        logic [ADDR_W-1:0] addr;
        logic              mode;
        int unsigned       pick;
        int unsigned       k;
        int                lim;
        page_run_t         held;
        lim  = managed_pages();
        pick = $urandom_range(0, 99);
        addr = $urandom();
        if (pick < 45 || (pick < 80 && held_runs.size() == 0))
        begin
            k = $urandom_range(0, 9);
            if (k < 6)
                cnt = CNT_W'($urandom_range(1, 8));
            else if (k < 8)
                cnt = CNT_W'($urandom_range(1, 64));
            else if (k < 9)
                cnt = CNT_W'($urandom_range(1, (lim == 0) ? 1 : lim));
            else
                cnt = CNT_W'($urandom_range(0, 2047));
            issue_request(MODE_ALLOC, cnt, addr, PREDICTED, '0);
        end
        else if (pick < 80)
        begin
            k    = $urandom_range(0, held_runs.size() - 1);
            held = held_runs[k];
            held_runs.delete(k);
            addr = held.addr;
            // now and then point somewhere inside the first page
            if ($urandom_range(0, 3) == 0 && cfg_shift != 0)
                addr = addr + ($urandom() & ((32'd1 << cfg_shift) - 32'd1));
            issue_request(MODE_FREE, held.cnt, addr, PREDICTED, '0);
        end
        else
        begin
            mode = ($urandom_range(0, 4) == 0) ? MODE_ALLOC : MODE_FREE;
            case ($urandom_range(0, 3))
                0: cnt = '0;
                1: cnt = CNT_W'($urandom_range(1, 16));
                2:
                begin
                    // page up to one past the last managed one, length 1 to 32; may run off the end
                    addr = cfg_base + (ADDR_W'($urandom_range(0, lim)) << cfg_shift);
                    cnt  = CNT_W'($urandom_range(1, 32));
                end
                default: cnt = CNT_W'($urandom_range(0, 2047));
            endcase
            issue_request(mode, cnt, addr, PREDICTED, '0);
        end
    endtask

    // Stop offering and wait for every queued result; the unit is idle once
    // the last one is taken, the short pause just keeps writes clear of it.
    task automatic drain_results();
        s_tvalid   <= 1'b0;
        burst_left = 0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // One register write; valid is left high for back-to-back writes.
    task automatic write_reg(input logic [REGIDX_W-1:0] idx, input logic [ADDR_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_BASE_ADDR:    cfg_base  = val;
            CFG_PAGE_SHIFT:   cfg_shift = val[SHIFT_W-1:0];
            CFG_USABLE_PAGES: cfg_pages = val[CNT_W-1:0];
            default: ;
        endcase
    endtask

    // Drain, reprogram all three registers, wipe the managed pages under the
    // new layout, then run random traffic.
    task automatic run_setting(input logic [ADDR_W-1:0] base, input logic [SHIFT_W-1:0] shift,
                               input logic [CNT_W-1:0] pages, input int n_req);
        drain_results();
        write_reg(CFG_BASE_ADDR, base);
        write_reg(CFG_PAGE_SHIFT, ADDR_W'(shift));
        write_reg(CFG_USABLE_PAGES, ADDR_W'(pages));
        cfg_valid <= 1'b0;
        @(posedge clk);
        held_runs.delete();
        issue_request(MODE_FREE, CNT_W'(managed_pages()), cfg_base, PREDICTED, '0);
        repeat (n_req) random_request();
    endtask

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed table at reset settings; the unit sweeps its map first,
        // which simply holds off the first transfer
        foreach (DIR_ROWS[r])
            issue_request(DIR_ROWS[r].mode, DIR_ROWS[r].cnt, DIR_ROWS[r].addr,
                          DIR_ROWS[r].typed,
                          '{addr: DIR_ROWS[r].exp_addr, ok: DIR_ROWS[r].exp_ok});

        // random traffic at reset settings
        repeat (500) random_request();

        // nothing managed, zero base, byte pages
        run_setting(32'h0000_0000, 5'd0, 11'd0, 40);
        // small map, byte pages
        run_setting(32'h0000_0000, 5'd0, 11'd64, 300);
        // top base wraps every address; usable above depth clamps to 1024
        run_setting(32'hFFFF_FFFF, 5'd20, 11'h7FF, 300);

        // widest shift; the unmapped index must not disturb anything
        drain_results();
        write_reg(CFG_UNMAPPED, $urandom());
        cfg_valid <= 1'b0;
        run_setting(32'h8000_0000, 5'd31, 11'd1024, 150);

        // a few random layouts
        repeat (3)
            run_setting($urandom(), SHIFT_W'($urandom_range(0, 20)),
                        CNT_W'(($urandom_range(0, 1) == 0) ? $urandom_range(1, 96)
                                                            : $urandom_range(1, 1024)),
                        230);

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_cnt == 0)
            $display("tb_bitmap_page_frame_allocator_unit: PASS");
        else
            $display("tb_bitmap_page_frame_allocator_unit: FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // Result side: checker plus sink stall pattern
    // ------------------------------------------------------------------
    initial
    begin : result_sink
        frame_result_t exp_res;
        int unsigned   taken;
        int unsigned   hold_left;
        int unsigned   style;
        int unsigned   style_left;
        logic          rdy;
        taken      = 0;
        hold_left  = 0;
        style      = 0;
        style_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
            begin
                if (pending_results.size() == 0)
                    report_mismatch($sformatf("unexpected result addr=%h ok=%b",
                                              m_tdata, m_tuser));
                else
                begin
                    exp_res = pending_results.pop_front();
                    if (m_tdata !== exp_res.addr)
                        report_mismatch($sformatf("result_addr %h, expected %h",
                                                  m_tdata, exp_res.addr));
                    if (m_tuser !== exp_res.ok)
                        report_mismatch($sformatf("ok %b, expected %b (addr %h)",
                                                  m_tuser, exp_res.ok, exp_res.addr));
                end
                taken++;
                // long hold-offs while the request side keeps pushing, so the
                // unit backs up and drops s_tready
                if (taken == 200 || taken == 1000)
                    hold_left = HOLD_CYCLES;
            end

            if (hold_left != 0)
            begin
                hold_left--;
                rdy = 1'b0;
            end
            else
            begin
                if (style_left == 0)
                begin
                    style      = $urandom_range(0, 3);
                    style_left = $urandom_range(50, 300);
                end
                style_left--;
                case (style)
                    0: rdy = 1'b1;                             // always ready
                    1: rdy = 1'($urandom_range(0, 1));         // coin flip
                    2: rdy = ($urandom_range(0, 9) != 0);      // rare stalls
                    default: rdy = (style_left % 4 == 0);      // one in four
                endcase
            end
            m_tready <= rdy;
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: too long without any transfer on any channel
    // ------------------------------------------------------------------
    int unsigned quiet_cycles = 0;

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles == QUIET_LIMIT)
        begin
            $display("tb_bitmap_page_frame_allocator_unit: FAIL");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

endmodule

// File: bitmap_page_frame_allocator_unit.f
rtl/bpfa_pkg.sv
rtl/bpfa_ctrl.sv
rtl/bpfa_datapath.sv
rtl/bitmap_page_frame_allocator_unit.sv
dv/tb_bitmap_page_frame_allocator_unit.sv
